>>> sv/tracking_frame_axis_rate_control_defines.svh
// Assertion macros shared by the tracking frame rate control RTL.
`ifndef TRACKING_FRAME_AXIS_RATE_CONTROL_DEFINES_SVH
`define TRACKING_FRAME_AXIS_RATE_CONTROL_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define TFARC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tfarc check failed");
// Property checked at the clock edge that follows a trigger condition.
`define TFARC_ASSERT_STEP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("tfarc check failed");
`else
`define TFARC_ASSERT(label, clk, rstn, prop)
`define TFARC_ASSERT_STEP(label, clk, rstn, cond, prop)
`endif
`endif

>>> sv/tfarc_pkg.sv
// Types, codes and reset values for the tracking frame rate control block.
package tfarc_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] HDR_A = 8'hFC;
    localparam logic [7:0] HDR_B = 8'hCF;

    // Event kinds on the input channel
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_LINE_ERR = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    // Result actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_DRIVE = 2'd1;
    localparam logic [1:0] ACT_HOLD  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_INVERT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_INVERT   = 4'd7;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_DEAD_BAND  = 8'd3;
    localparam logic [15:0] RST_MIN_RATE   = 16'd200;
    localparam logic [15:0] RST_MAX_RATE   = 16'd4000;
    localparam logic [7:0]  RST_GAIN       = 8'd15;
    localparam logic [15:0] RST_TIMEOUT_MS = 16'd200;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_HDR2  = 3'd1,
        PH_PAY0  = 3'd2,
        PH_PAY1  = 3'd3,
        PH_PAY2  = 3'd4,
        PH_PAY3  = 3'd5,
        PH_TAIL1 = 3'd6,
        PH_TAIL2 = 3'd7
    } phase_t;

    typedef struct packed {
        logic        enable;
        logic [7:0]  dead_band;
        logic [15:0] min_rate;
        logic [15:0] max_rate;
        logic [7:0]  gain;
        logic [15:0] timeout_ms;
        logic        pitch_invert;
        logic        yaw_invert;
    } cfg_t;

    // Outcome of one transaction as decided by the frame parser
    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] err_x;
        logic signed [15:0] err_y;
        logic [31:0]        good;
        logic [31:0]        bad;
    } step_t;

endpackage

>>> sv/tracking_frame_axis_rate_control.sv
// Top level of the tracking frame rate control block.
//
// The input channel carries one UART event per transaction: a received byte,
// a line error or a millisecond tick. Every input transaction yields exactly
// one result transaction, in order, carrying the action, the pitch and yaw
// commands, the held X and Y errors and the frame counters.
// The write port sets the eight control registers; write only while idle.
// The datapath is a four-register pipeline: input register, parser result,
// axis magnitude stage and output register. One transaction is taken every
// cycle when the output is drained; the single 16 by 8 multiply per axis
// sets the stage split.
// When the receiver stalls, results fill the stages behind the output
// register and s_ready falls once all four stages hold a transaction.
// Synchronous reset empties the pipeline, returns the parser to hunting
// for a header, zeroes the counters, held errors and tick time, and loads
// the register defaults.
`include "tracking_frame_axis_rate_control_defines.svh"
module tracking_frame_axis_rate_control (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tfarc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfarc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_kind,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_action,
    output logic                             m_pitch_run,
    output logic                             m_pitch_reverse,
    output logic [15:0]                      m_pitch_rate,
    output logic                             m_yaw_run,
    output logic                             m_yaw_reverse,
    output logic [15:0]                      m_yaw_rate,
    output logic signed [15:0]               m_last_err_x,
    output logic signed [15:0]               m_last_err_y,
    output logic [31:0]                      m_good_frames,
    output logic [31:0]                      m_bad_frames
);
    import tfarc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic [3:0] v_reg, v_next;
    logic [3:0] rdy;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    step_t      step_next;
    step_t      st1_reg, st2_reg, st3_reg;
    logic       step_en;
    logic       drive;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENABLE:       cfg_next.enable       = cfg_wdata[0];
                REG_DEAD_BAND:    cfg_next.dead_band    = cfg_wdata[7:0];
                REG_MIN_RATE:     cfg_next.min_rate     = cfg_wdata;
                REG_MAX_RATE:     cfg_next.max_rate     = cfg_wdata;
                REG_GAIN:         cfg_next.gain         = cfg_wdata[7:0];
                REG_TIMEOUT_MS:   cfg_next.timeout_ms   = cfg_wdata;
                REG_PITCH_INVERT: cfg_next.pitch_invert = cfg_wdata[0];
                REG_YAW_INVERT:   cfg_next.yaw_invert   = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.dead_band    <= RST_DEAD_BAND;
            cfg_reg.min_rate     <= RST_MIN_RATE;
            cfg_reg.max_rate     <= RST_MAX_RATE;
            cfg_reg.gain         <= RST_GAIN;
            cfg_reg.timeout_ms   <= RST_TIMEOUT_MS;
            cfg_reg.pitch_invert <= 1'b0;
            cfg_reg.yaw_invert   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // A stage can take a transaction when it is empty or its contents move on.
    always_comb begin
        rdy[3] = !v_reg[3] || m_ready;
        for (int k = 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? s_valid : v_reg[0];
        for (int k = 1; k < 4; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = rdy[0];
    assign step_en = v_reg[0] && rdy[1];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            kind_reg <= s_kind;
            byte_reg <= s_rx_byte;
        end
        if (rdy[1]) begin
            st1_reg <= step_next;
        end
        if (rdy[2]) begin
            st2_reg <= st1_reg;
        end
        if (rdy[3]) begin
            st3_reg <= st2_reg;
        end
    end

    tfarc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .kind    (kind_reg),
        .rx_byte (byte_reg),
        .cfg     (cfg_reg),
        .step    (step_next)
    );

    assign drive = (st1_reg.action == ACT_DRIVE);

    tfarc_axis u_pitch (
        .aclk      (aclk),
        .load_a    (rdy[2]),
        .load_b    (rdy[3]),
        .drive     (drive),
        .err       (st1_reg.err_y),
        .invert    (cfg_reg.pitch_invert),
        .dead_band (cfg_reg.dead_band),
        .min_rate  (cfg_reg.min_rate),
        .max_rate  (cfg_reg.max_rate),
        .gain      (cfg_reg.gain),
        .run       (m_pitch_run),
        .reverse   (m_pitch_reverse),
        .rate      (m_pitch_rate)
    );

    tfarc_axis u_yaw (
        .aclk      (aclk),
        .load_a    (rdy[2]),
        .load_b    (rdy[3]),
        .drive     (drive),
        .err       (st1_reg.err_x),
        .invert    (cfg_reg.yaw_invert),
        .dead_band (cfg_reg.dead_band),
        .min_rate  (cfg_reg.min_rate),
        .max_rate  (cfg_reg.max_rate),
        .gain      (cfg_reg.gain),
        .run       (m_yaw_run),
        .reverse   (m_yaw_reverse),
        .rate      (m_yaw_rate)
    );

    assign m_valid       = v_reg[3];
    assign m_action      = st3_reg.action;
    assign m_last_err_x  = st3_reg.err_x;
    assign m_last_err_y  = st3_reg.err_y;
    assign m_good_frames = st3_reg.good;
    assign m_bad_frames  = st3_reg.bad;

    `TFARC_ASSERT(a_quiet_axes, aclk, aresetn, m_valid && m_action != ACT_DRIVE |-> !m_pitch_run && !m_yaw_run && m_pitch_rate == 16'd0 && m_yaw_rate == 16'd0)
    `TFARC_ASSERT(a_rate_cap, aclk, aresetn, m_valid && m_pitch_run |-> m_pitch_rate <= cfg_reg.max_rate)
    `TFARC_ASSERT(a_full_stall, aclk, aresetn, !s_ready |-> v_reg == 4'hF && !m_ready)
    `TFARC_ASSERT_STEP(a_drain, aclk, aresetn, m_valid && m_ready && !v_reg[2], !m_valid)

endmodule

>>> sv/tfarc_parser.sv
// Frame parser, tick timer, held errors and frame counters.
`include "tracking_frame_axis_rate_control_defines.svh"
module tfarc_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [1:0]       kind,
    input  logic [7:0]       rx_byte,
    input  tfarc_pkg::cfg_t  cfg,
    output tfarc_pkg::step_t step
);
    import tfarc_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         pay_reg [4];
    logic [3:0]         pay_wr;
    logic [31:0]        ms_now_reg, ms_now_next;
    logic [31:0]        ms_last_reg, ms_last_next;
    logic signed [15:0] err_x_reg, err_x_next;
    logic signed [15:0] err_y_reg, err_y_next;
    logic [31:0]        good_reg, good_next;
    logic [31:0]        bad_reg, bad_next;
    logic [1:0]         action;
    phase_t             restart;
    logic [31:0]        elapsed;

    always_comb begin
        phase_next   = phase_reg;
        pay_wr       = '0;
        ms_now_next  = ms_now_reg;
        ms_last_next = ms_last_reg;
        err_x_next   = err_x_reg;
        err_y_next   = err_y_reg;
        good_next    = good_reg;
        bad_next     = bad_reg;
        action       = ACT_NONE;
        restart      = (rx_byte == HDR_A) ? PH_HDR2 : PH_HUNT;
        elapsed      = ms_now_reg + 32'd1 - ms_last_reg;
        case (kind)
            KIND_BYTE: begin
                case (phase_reg)
                    PH_HUNT: phase_next = restart;
                    PH_HDR2: phase_next = (rx_byte == HDR_B) ? PH_PAY0 : restart;
                    PH_PAY0: begin
                        pay_wr[0]  = 1'b1;
                        phase_next = PH_PAY1;
                    end
                    PH_PAY1: begin
                        pay_wr[1]  = 1'b1;
                        phase_next = PH_PAY2;
                    end
                    PH_PAY2: begin
                        pay_wr[2]  = 1'b1;
                        phase_next = PH_PAY3;
                    end
                    PH_PAY3: begin
                        pay_wr[3]  = 1'b1;
                        phase_next = PH_TAIL1;
                    end
                    PH_TAIL1: begin
                        if (rx_byte == HDR_B) begin
                            phase_next = PH_TAIL2;
                        end else begin
                            bad_next   = bad_reg + 32'd1;
                            phase_next = restart;
                        end
                    end
                    PH_TAIL2: begin
                        if (rx_byte == HDR_A) begin
                            good_next = good_reg + 32'd1;
                            if (cfg.enable) begin
                                err_x_next   = {pay_reg[1], pay_reg[0]};
                                err_y_next   = {pay_reg[3], pay_reg[2]};
                                ms_last_next = ms_now_reg;
                                action       = ACT_DRIVE;
                            end else begin
                                action = ACT_HOLD;
                            end
                        end else begin
                            bad_next = bad_reg + 32'd1;
                        end
                        phase_next = restart;
                    end
                    default: phase_next = PH_HUNT;
                endcase
            end
            KIND_LINE_ERR: begin
                bad_next   = bad_reg + 32'd1;
                phase_next = PH_HUNT;
            end
            KIND_TICK: begin
                ms_now_next = ms_now_reg + 32'd1;
                // The difference wraps with the tick counter, as intended.
                if (!cfg.enable || elapsed > 32'(cfg.timeout_ms)) begin
                    action = ACT_HOLD;
                end
            end
            default: ;
        endcase
    end

    assign step.action = action;
    assign step.err_x  = err_x_next;
    assign step.err_y  = err_y_next;
    assign step.good   = good_next;
    assign step.bad    = bad_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            ms_now_reg  <= '0;
            ms_last_reg <= '0;
            err_x_reg   <= '0;
            err_y_reg   <= '0;
            good_reg    <= '0;
            bad_reg     <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            ms_now_reg  <= ms_now_next;
            ms_last_reg <= ms_last_next;
            err_x_reg   <= err_x_next;
            err_y_reg   <= err_y_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (step_en && pay_wr[i]) begin
                pay_reg[i] <= rx_byte;
            end
        end
    end

    `TFARC_ASSERT_STEP(a_bad_only_on_step, aclk, aresetn, !step_en, bad_reg == $past(bad_reg))
    `TFARC_ASSERT_STEP(a_tick_only_on_step, aclk, aresetn, !step_en, ms_now_reg == $past(ms_now_reg))

endmodule

>>> sv/tfarc_axis.sv
// Two-stage rate calculation for one motor axis.
module tfarc_axis (
    input  logic               aclk,
    input  logic               load_a,
    input  logic               load_b,
    input  logic               drive,
    input  logic signed [15:0] err,
    input  logic               invert,
    input  logic [7:0]         dead_band,
    input  logic [15:0]        min_rate,
    input  logic [15:0]        max_rate,
    input  logic [7:0]         gain,
    output logic               run,
    output logic               reverse,
    output logic [15:0]        rate
);
    logic [15:0] mag;
    logic        run_a_reg;
    logic        rev_a_reg;
    logic [15:0] excess_a_reg;
    logic [23:0] product;
    logic [24:0] sum;
    logic [15:0] clamped;
    logic        run_reg;
    logic        rev_reg;
    logic [15:0] rate_reg;

    // The most negative error gives 0x8000, which is its true magnitude.
    assign mag = err[15] ? 16'(-err) : 16'(err);

    always_ff @(posedge aclk) begin
        if (load_a) begin
            run_a_reg    <= drive && (mag > {8'd0, dead_band});
            rev_a_reg    <= err[15] ^ invert;
            excess_a_reg <= mag - {8'd0, dead_band};
        end
    end

    assign product = excess_a_reg * gain;
    assign sum     = 25'(product) + 25'(min_rate);
    assign clamped = (sum > 25'(max_rate)) ? max_rate : sum[15:0];

    always_ff @(posedge aclk) begin
        if (load_b) begin
            run_reg  <= run_a_reg;
            rev_reg  <= run_a_reg && rev_a_reg;
            rate_reg <= run_a_reg ? clamped : 16'd0;
        end
    end

    assign run     = run_reg;
    assign reverse = rev_reg;
    assign rate    = rate_reg;

endmodule
